FILE: hw/rtl/clm_pkg.sv
package clm_pkg;

  localparam int ROWS   = 5;
  localparam int ROW_W  = 3;
  localparam int COL_W  = 13;
  localparam int DOT_BIT = 6;

  localparam logic [6:0]  TICK_LAST    = 7'd100;
  localparam logic [6:0]  SAMPLE_LAST  = 7'd100;
  localparam logic [6:0]  BRIGHT_RESET = 7'd100;
  localparam logic [15:0] DOT_TIMEOUT_RESET = 16'd500;
  localparam logic [6:0]  DIGIT_MAX    = 7'd99;

  // rows whose dot bit the timeout clears (rows 1, 3 and 4)
  localparam logic [ROWS-1:0] DOT_CLEAR_ROWS = 5'b11010;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_LOAD   = 2'd1,
    ACT_DOT    = 2'd2,
    ACT_SAMPLE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    DOT_NONE      = 3'd0,
    DOT_COLON     = 3'd1,
    DOT_SEMICOLON = 3'd2,
    DOT_PERIOD    = 3'd3,
    DOT_COMMA     = 3'd4
  } dot_mode_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [6:0]  hours;
    logic [6:0]  minutes;
    logic [2:0]  dot_mode;
    logic [11:0] light_level;
  } item_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_select;
    logic             row_on;
    logic [COL_W-1:0] column_bits;
    logic             sample_request;
    logic [6:0]       brightness;
  } result_t;

  // 3x5 font, top row in the high three bits
  localparam logic [14:0] GLYPH [10] = '{
    15'o75557, 15'o22222, 15'o71747, 15'o71717, 15'o55711,
    15'o74717, 15'o74757, 15'o71111, 15'o75757, 15'o75717
  };

  function automatic logic [2:0] glyph_row(input logic [3:0] digit, input int row);
    logic [14:0] g;
    g = GLYPH[digit];
    return g[3*(ROWS-1-row) +: 3];
  endfunction

  function automatic logic [ROWS-1:0] dot_rows(input logic [2:0] mode);
    logic [ROWS-1:0] m;
    case (mode)
      DOT_COLON:     m = 5'b01010;
      DOT_SEMICOLON: m = 5'b11010;
      DOT_PERIOD:    m = 5'b10000;
      DOT_COMMA:     m = 5'b11000;
      default:       m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [6:0] level_of(input logic [11:0] ad);
    logic [6:0] lv;
    if (ad >= 12'd2500)      lv = 7'd100;
    else if (ad >= 12'd1500) lv = 7'd64;
    else if (ad >= 12'd1000) lv = 7'd32;
    else if (ad >= 12'd500)  lv = 7'd16;
    else if (ad >= 12'd250)  lv = 7'd8;
    else if (ad >= 12'd100)  lv = 7'd4;
    else if (ad >= 12'd50)   lv = 7'd2;
    else                     lv = 7'd1;
    return lv;
  endfunction

endpackage

FILE: hw/rtl/clock_led_matrix_scanner.sv
// Scanner for a 5-row, 13-column multiplexed clock display. Each request
// (tick, frame load, dot timer restart or light sample reply) gives exactly
// one result carrying the driven row, its on flag, the column pattern, a
// light sample request pulse and the current brightness. A request is
// latched in an input register, passes one step of logic into the result
// register, and the block takes one request per clock unless the result
// side stalls. The input register and the result register together buffer
// two requests, so one more request is taken while a result waits; after
// that in_stall follows out_stall in the same cycle. A frame load takes
// effect at once; the row drive changes only on ticks. dot_timeout may be
// written only while no request is in flight.
module clock_led_matrix_scanner
  import clm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             dot_timeout_we,
  input  logic [15:0]      dot_timeout_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       action,
  input  logic [6:0]       hours,
  input  logic [6:0]       minutes,
  input  logic [2:0]       dot_mode,
  input  logic [11:0]      light_level,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [ROW_W-1:0] row_select,
  output logic             row_on,
  output logic [COL_W-1:0] column_bits,
  output logic             sample_request,
  output logic [6:0]       brightness
);

  logic [15:0] dot_timeout_reg;
  logic        s1_valid;
  item_t       s1_item;
  logic        out_open;
  logic        s1_adv;
  result_t     res;
  result_t     res_reg;

  assign out_open = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && out_open;
  assign in_stall = s1_valid && !out_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_timeout_reg <= DOT_TIMEOUT_RESET;
    end else if (dot_timeout_we) begin
      dot_timeout_reg <= dot_timeout_data;
    end
  end

  // input register: hold while the result side is blocked
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= '{action: action, hours: hours, minutes: minutes,
                   dot_mode: dot_mode, light_level: light_level};
    end
  end

  clm_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (s1_adv),
    .item        (s1_item),
    .dot_timeout (dot_timeout_reg),
    .result      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_open) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_reg <= res;
    end
  end

  assign row_select     = res_reg.row_select;
  assign row_on         = res_reg.row_on;
  assign column_bits    = res_reg.column_bits;
  assign sample_request = res_reg.sample_request;
  assign brightness     = res_reg.brightness;

endmodule

FILE: hw/rtl/clm_render.sv
module clm_render
  import clm_pkg::*;
(
  input  logic [6:0]       hours,
  input  logic [6:0]       minutes,
  input  logic [2:0]       dot_mode,
  output logic [COL_W-1:0] frame [ROWS]
);

  // split a value 0..99 into tens and ones; tens = (v * 205) >> 11
  function automatic logic [7:0] split_digits(input logic [6:0] v);
    logic [6:0]  sat;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens10;
    logic [6:0]  ones;
    sat    = (v > DIGIT_MAX) ? DIGIT_MAX : v;
    prod   = 15'(sat) * 15'd205;
    tens   = prod[14:11];
    tens10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
    ones   = sat - tens10;
    return {tens, ones[3:0]};
  endfunction

  logic [7:0]      h_dig;
  logic [7:0]      m_dig;
  logic [ROWS-1:0] dots;

  always_comb begin
    h_dig = split_digits(hours);
    m_dig = split_digits(minutes);
    dots  = dot_rows(dot_mode);
    for (int r = 0; r < ROWS; r++) begin
      frame[r] = {glyph_row(h_dig[7:4], r), glyph_row(h_dig[3:0], r), dots[r],
                  glyph_row(m_dig[7:4], r), glyph_row(m_dig[3:0], r)};
    end
  end

endmodule

FILE: hw/rtl/clm_core.sv
module clm_core
  import clm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  item_t       item,
  input  logic [15:0] dot_timeout,
  output result_t     result
);

  logic [COL_W-1:0] frame_rows [ROWS];
  logic [COL_W-1:0] frame_rows_next [ROWS];
  logic [COL_W-1:0] load_frame [ROWS];
  logic [6:0]       tick_count, tick_count_next, tick_inc;
  logic [ROW_W-1:0] scan_row, scan_row_next;
  logic [6:0]       sample_count, sample_count_next;
  logic [15:0]      dot_timer, dot_timer_next;
  logic [6:0]       bright_level, bright_level_next;
  logic             sample_pending, sample_pending_next;
  logic [ROW_W-1:0] drive_row, drive_row_next;
  logic             drive_on, drive_on_next;
  logic [COL_W-1:0] drive_columns, drive_columns_next;
  logic             req;

  clm_render u_render (
    .hours    (item.hours),
    .minutes  (item.minutes),
    .dot_mode (item.dot_mode),
    .frame    (load_frame)
  );

  always_comb begin
    frame_rows_next     = frame_rows;
    tick_count_next     = tick_count;
    scan_row_next       = scan_row;
    sample_count_next   = sample_count;
    dot_timer_next      = dot_timer;
    bright_level_next   = bright_level;
    sample_pending_next = sample_pending;
    drive_row_next      = drive_row;
    drive_on_next       = drive_on;
    drive_columns_next  = drive_columns;
    req                 = 1'b0;
    tick_inc            = tick_count + 7'd1;

    case (action_t'(item.action))
      ACT_TICK: begin
        tick_count_next = tick_inc;
        // blank once the on-time is used up
        if (tick_inc >= bright_level) begin
          drive_on_next      = 1'b0;
          drive_columns_next = '0;
        end
        if (tick_inc > TICK_LAST) begin
          tick_count_next = '0;
          if (dot_timer >= dot_timeout) begin
            for (int r = 0; r < ROWS; r++) begin
              if (DOT_CLEAR_ROWS[r]) frame_rows_next[r][DOT_BIT] = 1'b0;
            end
          end else begin
            dot_timer_next = dot_timer + 16'd1;
          end
          drive_row_next     = scan_row;
          drive_on_next      = 1'b1;
          drive_columns_next = frame_rows_next[scan_row];
          scan_row_next = (scan_row >= ROW_W'(ROWS - 1)) ? '0 : scan_row + ROW_W'(1);
          if (sample_count > SAMPLE_LAST) begin
            sample_pending_next = 1'b1;
            sample_count_next   = '0;
            req                 = 1'b1;
          end else begin
            sample_count_next = sample_count + 7'd1;
          end
        end
      end
      ACT_LOAD: frame_rows_next = load_frame;
      ACT_DOT:  dot_timer_next = '0;
      ACT_SAMPLE: begin
        if (sample_pending) begin
          sample_pending_next = 1'b0;
          bright_level_next   = level_of(item.light_level);
        end
      end
      default: ;
    endcase

    result.row_select     = drive_row_next;
    result.row_on         = drive_on_next;
    result.column_bits    = drive_columns_next;
    result.sample_request = req;
    result.brightness     = bright_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) frame_rows[r] <= '0;
      tick_count     <= '0;
      scan_row       <= '0;
      sample_count   <= '0;
      dot_timer      <= '0;
      bright_level   <= BRIGHT_RESET;
      sample_pending <= 1'b0;
      drive_row      <= '0;
      drive_on       <= 1'b0;
      drive_columns  <= '0;
    end else if (step) begin
      frame_rows     <= frame_rows_next;
      tick_count     <= tick_count_next;
      scan_row       <= scan_row_next;
      sample_count   <= sample_count_next;
      dot_timer      <= dot_timer_next;
      bright_level   <= bright_level_next;
      sample_pending <= sample_pending_next;
      drive_row      <= drive_row_next;
      drive_on       <= drive_on_next;
      drive_columns  <= drive_columns_next;
    end
  end

endmodule
